@@ sv/udpq_pkg.sv @@
// ----------------------------------------------------------------------------
// UDP demux package
// Action and status codes, state type and fixed constants of the UDP port
// demultiplexer.
// ----------------------------------------------------------------------------
package udpq_pkg;

   typedef enum logic [2:0] {
      ACT_ALLOC   = 3'd0,
      ACT_BIND    = 3'd1,
      ACT_CONNECT = 3'd2,
      ACT_RECV    = 3'd3,
      ACT_DEQ     = 3'd4,
      ACT_CLOSE   = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_SHORT    = 4'd1,
      ST_BADLEN   = 4'd2,
      ST_NOLISTEN = 4'd3,
      ST_FULL     = 4'd4,
      ST_OVERRUN  = 4'd5,
      ST_NOFREE   = 4'd6,
      ST_BOUND    = 4'd7,
      ST_INUSE    = 4'd8,
      ST_EMPTY    = 4'd9
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ
   } state_type;

   localparam logic [15:0] HDR_LEN        = 16'd8;
   localparam logic [15:0] EPHEMERAL_BASE = 16'd49152;
   localparam logic [15:0] PORT_MAX       = 16'd65535;
   localparam logic [15:0] LIMIT_RESET    = 16'd2048;

endpackage

@@ sv/udp_port_demux_queues_unit.sv @@
// ----------------------------------------------------------------------------
// UDP port demultiplexer with receive rings
// Socket table with bind, connect and close, and per-socket descriptor rings
// held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one action word (allocate, bind, connect, receive, dequeue,
//  close); rsp_* returns exactly one result word per action, in order.
//  Both channels use valid/stall; the receiver drives stall.
//  csr_* writes payload_limit; csr_ready is always high.
//  An action is registered when taken and executed in the execute state: the
//  port match over the socket table and the ring update happen there.
//  A dequeue that finds data adds a read state for the registered read of
//  the descriptor memory. No new action is taken until the last has left
//  those states; rsp_valid rises when a result enters the output register.
//  A stalled result is held in the output register; the block keeps the
//  next action in its execute stage until that register frees.
//  Reset clears all socket marks, ring pointers and the ephemeral counter
//  (49152) and sets payload_limit to 2048; descriptor contents need no reset.
// ----------------------------------------------------------------------------
module udp_port_demux_queues_unit #(
   parameter int SOCKETS     = 32,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [4:0]  req_socket_id,
   input  logic [15:0] req_port_number,
   input  logic [31:0] req_ip_addr,
   input  logic [15:0] req_peer_port,
   input  logic [15:0] req_udp_length,
   input  logic [15:0] req_packet_length,
   input  logic [15:0] req_read_limit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [4:0]  rsp_out_socket,
   output logic [15:0] rsp_out_port,
   output logic [3:0]  rsp_queue_slot,
   output logic [15:0] rsp_out_length,
   output logic [31:0] rsp_out_ip,
   output logic [15:0] rsp_out_peer_port,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_payload_limit
);
   import udpq_pkg::*;

   localparam int SW  = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
   localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int ENT = SOCKETS * QUEUE_DEPTH;
   localparam int AW  = (ENT > 1) ? $clog2(ENT) : 1;
   localparam int DW  = 64;

   state_type   state_ff, state_in;
   logic [2:0]  act_ff;
   logic [4:0]  sid_ff;
   logic [15:0] port_ff, peer_ff, ulen_ff, plen_ff, rlim_ff;
   logic [31:0] ip_ff;
   logic [15:0] limit_ff;
   logic [15:0] eph_ff;

   logic [SOCKETS-1:0] bound_ff;
   logic [SOCKETS-1:0] conn_ff;
   logic [15:0]        lport_ff [SOCKETS];
   logic [QW-1:0]      head_ff  [SOCKETS];
   logic [QW-1:0]      tail_ff  [SOCKETS];

   logic [DW-1:0] mem [ENT];
   logic [DW-1:0] rdata_ff;

   logic        rsp_valid_ff;
   logic [3:0]  status_ff;
   logic [4:0]  socket_ff;
   logic [15:0] oport_ff, length_ff, opeer_ff;
   logic [3:0]  slot_ff;
   logic [31:0] oip_ff;

   logic        rsp_load;
   logic [3:0]  status_in;
   logic [4:0]  socket_in;
   logic [15:0] oport_in, length_in, opeer_in;
   logic [3:0]  slot_in;
   logic [31:0] oip_in;

   logic          out_free;
   logic          sid_ok;
   logic [SW-1:0] sidx;
   logic [15:0]   bind_port, cmp_port, eph_next, pay;
   logic          match_found, free_found;
   logic [SW-1:0] match_idx, free_idx, ring_idx;
   logic [QW-1:0] ring_head, ring_tail, tail_next, head_next;
   logic [AW-1:0] mem_addr;

   logic          clr_en, bind_we, conn_we, tail_we, head_we, eph_we;
   logic          mem_we, mem_re;
   logic [SW-1:0] clr_idx;

   assign req_stall         = (state_ff != S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_socket    = socket_ff;
   assign rsp_out_port      = oport_ff;
   assign rsp_queue_slot    = slot_ff;
   assign rsp_out_length    = length_ff;
   assign rsp_out_ip        = oip_ff;
   assign rsp_out_peer_port = opeer_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign sid_ok   = (32'(sid_ff) < SOCKETS);
   assign sidx     = SW'(sid_ff);
   assign eph_next = (eph_ff == PORT_MAX) ? EPHEMERAL_BASE : eph_ff + 16'd1;
   assign bind_port = (port_ff == 16'd0) ? eph_ff : port_ff;
   assign cmp_port  = (act_ff == ACT_BIND) ? bind_port : port_ff;

   always_comb begin
      match_found = 1'b0;
      match_idx   = '0;
      free_found  = 1'b0;
      free_idx    = '0;
      for (int i = SOCKETS - 1; i >= 0; i--) begin
         if (bound_ff[i] && lport_ff[i] == cmp_port) begin
            match_found = 1'b1;
            match_idx   = SW'(i);
         end
         if (!bound_ff[i] && !conn_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   assign ring_idx  = (act_ff == ACT_RECV) ? match_idx : sidx;
   assign ring_head = head_ff[ring_idx];
   assign ring_tail = tail_ff[ring_idx];
   assign tail_next = (32'(ring_tail) == QUEUE_DEPTH - 1) ? '0 : ring_tail + QW'(1);
   assign head_next = (32'(ring_head) == QUEUE_DEPTH - 1) ? '0 : ring_head + QW'(1);
   assign mem_addr  = AW'(AW'(ring_idx) * AW'(QUEUE_DEPTH)) +
                      AW'((act_ff == ACT_RECV) ? ring_tail : ring_head);
   assign pay       = ((ulen_ff - HDR_LEN) > limit_ff) ? limit_ff : ulen_ff - HDR_LEN;

   always_comb begin
      state_in  = state_ff;
      rsp_load  = 1'b0;
      status_in = ST_OK;
      socket_in = '0;
      oport_in  = '0;
      slot_in   = '0;
      length_in = '0;
      oip_in    = '0;
      opeer_in  = '0;
      clr_en    = 1'b0;
      clr_idx   = sidx;
      bind_we   = 1'b0;
      conn_we   = 1'b0;
      tail_we   = 1'b0;
      head_we   = 1'b0;
      eph_we    = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               case (act_ff)
                  ACT_ALLOC: begin
                     if (free_found) begin
                        clr_en    = 1'b1;
                        clr_idx   = free_idx;
                        socket_in = 5'(free_idx);
                     end else begin
                        status_in = ST_NOFREE;
                     end
                  end
                  ACT_RECV: begin
                     if (plen_ff < HDR_LEN) begin
                        status_in = ST_SHORT;
                     end else if (ulen_ff < HDR_LEN || ulen_ff > plen_ff) begin
                        status_in = ST_BADLEN;
                     end else if (!match_found) begin
                        status_in = ST_NOLISTEN;
                     end else if (tail_next == ring_head) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        tail_we   = 1'b1;
                        socket_in = 5'(match_idx);
                        slot_in   = 4'(ring_tail);
                        length_in = pay;
                     end
                  end
                  ACT_BIND, ACT_CONNECT, ACT_DEQ, ACT_CLOSE: begin
                     if (!sid_ok) begin
                        status_in = ST_NOFREE;
                     end else if (act_ff == ACT_BIND) begin
                        if (bound_ff[sidx]) begin
                           status_in = ST_BOUND;
                        end else begin
                           eph_we = (port_ff == 16'd0);
                           if (match_found) begin
                              status_in = ST_INUSE;
                           end else begin
                              bind_we  = 1'b1;
                              oport_in = bind_port;
                           end
                        end
                     end else if (act_ff == ACT_CONNECT) begin
                        conn_we = 1'b1;
                     end else if (act_ff == ACT_DEQ) begin
                        if (ring_head == ring_tail) begin
                           status_in = ST_EMPTY;
                        end else begin
                           rsp_load = 1'b0;
                           mem_re   = 1'b1;
                           state_in = S_READ;
                        end
                     end else begin
                        clr_en = 1'b1;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               head_we   = 1'b1;
               state_in  = S_IDLE;
               slot_in   = 4'(ring_head);
               length_in = (rdata_ff[63:48] > rlim_ff) ? rlim_ff : rdata_ff[63:48];
               oip_in    = rdata_ff[47:16];
               opeer_in  = rdata_ff[15:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         eph_ff       <= EPHEMERAL_BASE;
         bound_ff     <= '0;
         conn_ff      <= '0;
         for (int i = 0; i < SOCKETS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) limit_ff <= csr_payload_limit;
         if (eph_we) eph_ff <= eph_next;
         if (clr_en) begin
            bound_ff[clr_idx] <= 1'b0;
            conn_ff[clr_idx]  <= 1'b0;
            head_ff[clr_idx]  <= '0;
            tail_ff[clr_idx]  <= '0;
         end
         if (bind_we) bound_ff[sidx] <= 1'b1;
         if (conn_we) conn_ff[sidx] <= 1'b1;
         if (tail_we) tail_ff[ring_idx] <= tail_next;
         if (head_we) head_ff[ring_idx] <= head_next;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         act_ff  <= req_action;
         sid_ff  <= req_socket_id;
         port_ff <= req_port_number;
         ip_ff   <= req_ip_addr;
         peer_ff <= req_peer_port;
         ulen_ff <= req_udp_length;
         plen_ff <= req_packet_length;
         rlim_ff <= req_read_limit;
      end
      if (bind_we) lport_ff[sidx] <= bind_port;
      if (rsp_load) begin
         status_ff <= status_in;
         socket_ff <= socket_in;
         oport_ff  <= oport_in;
         slot_ff   <= slot_in;
         length_ff <= length_in;
         oip_ff    <= oip_in;
         opeer_ff  <= opeer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= {pay, ip_ff, peer_ff};
      if (mem_re) rdata_ff <= mem[mem_addr];
   end

endmodule

@@ sv/udpq_checker.sv @@
// ----------------------------------------------------------------------------
// UDP demux port checker
// Port-level properties of the UDP port demultiplexer, bound to the top level.
// ----------------------------------------------------------------------------
module udpq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_status,
   input logic [15:0] rsp_out_length
);
   import udpq_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_length))
      else $error("stalled result changed");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("new word taken while executing");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without an action in progress");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_EMPTY)
      else $error("status code out of range");

endmodule

bind udp_port_demux_queues_unit udpq_checker u_udpq_checker (.*);
